// File: rtl/pls_pkg.sv
// ----------------------------------------------------------------------------
// pls_pkg: shared types and constants for the positional list store
// Holds the list capacity, the derived widths, the request codes and the
// packed types of the request, the result and the broadcast to the cells.
// ----------------------------------------------------------------------------
package pls_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int POS_W = 5;
  localparam int VAL_W = 32;
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [1:0] ACT_APPEND = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;
  localparam logic [1:0] ACT_READ   = 2'd3;

  localparam logic signed [VAL_W-1:0] NO_VALUE = '1;

  typedef struct packed {
    logic [1:0]              action;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] item_value;
  } pls_in_t;

  typedef struct packed {
    logic                    success;
    logic signed [VAL_W-1:0] read_value;
    logic [POS_W-1:0]        length;
  } pls_out_t;

  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [CMP_W-1:0] pos;
    logic [VAL_W-1:0] value;
  } pls_bcast_t;

endpackage

// File: rtl/positional_list_store.sv
// ----------------------------------------------------------------------------
// positional_list_store: bounded ordered list with positional access
// A row of cells holds the items in order; inserts and removals shift the
// cells behind the position by one place.
// ----------------------------------------------------------------------------
// A request is taken on every cycle in which start is high; busy is never
// raised, so one request per clock is sustained. Each request gives exactly
// one result, shown on out_data with out_strobe high for a single cycle, in the
// cycle after the request is taken. The receiver cannot stall the block, so every
// result must be captured in that cycle. The cells shift in parallel, and
// a read is served from a multiplexer over the cells.
module positional_list_store (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  pls_pkg::pls_in_t    in_data,
  output logic                out_strobe,
  output pls_pkg::pls_out_t   out_data
);

  logic [pls_pkg::CNT_W-1:0] count_r;
  logic [pls_pkg::CNT_W-1:0] count_nxt;
  logic                      out_strobe_r;
  pls_pkg::pls_out_t         out_data_r;
  pls_pkg::pls_out_t         out_data_nxt;
  pls_pkg::pls_bcast_t       bcast;

  logic [pls_pkg::VAL_W-1:0] cell_val [pls_pkg::DEPTH];

  logic                      accept;
  logic                      full;
  logic [pls_pkg::CMP_W-1:0] pos_ext;
  logic [pls_pkg::CMP_W-1:0] cnt_ext;
  logic                      ok;

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign full    = (count_r == pls_pkg::CNT_W'(pls_pkg::DEPTH));
  assign pos_ext = pls_pkg::CMP_W'(in_data.position);
  assign cnt_ext = pls_pkg::CMP_W'(count_r);

  always_comb begin
    ok            = 1'b0;
    bcast.ins     = 1'b0;
    bcast.rem     = 1'b0;
    bcast.pos     = pos_ext;
    bcast.value   = in_data.item_value;
    count_nxt     = count_r;
    out_data_nxt.read_value = pls_pkg::NO_VALUE;
    case (in_data.action)
      pls_pkg::ACT_APPEND: begin
        ok        = !full;
        bcast.pos = cnt_ext;
        bcast.ins = accept && ok;
      end
      pls_pkg::ACT_INSERT: begin
        ok        = !full && (pos_ext <= cnt_ext);
        bcast.ins = accept && ok;
      end
      pls_pkg::ACT_REMOVE: begin
        ok        = (pos_ext < cnt_ext);
        bcast.rem = accept && ok;
      end
      pls_pkg::ACT_READ: begin
        ok = (pos_ext < cnt_ext);
        if (ok) begin
          out_data_nxt.read_value = cell_val[pos_ext[pls_pkg::IDX_W-1:0]];
        end
      end
      default: begin
        ok = 1'b0;
      end
    endcase
    if (bcast.ins) begin
      count_nxt = count_r + pls_pkg::CNT_W'(1);
    end else if (bcast.rem) begin
      count_nxt = count_r - pls_pkg::CNT_W'(1);
    end
    out_data_nxt.success = ok;
    out_data_nxt.length  = pls_pkg::POS_W'(count_nxt);
  end

  for (genvar i = 0; i < pls_pkg::DEPTH; i++) begin : g_cell
    logic [pls_pkg::VAL_W-1:0] left_val;
    logic [pls_pkg::VAL_W-1:0] right_val;

    if (i == 0) begin : g_first
      assign left_val = cell_val[i];
    end else begin : g_mid_l
      assign left_val = cell_val[i-1];
    end

    if (i == pls_pkg::DEPTH - 1) begin : g_last
      assign right_val = cell_val[i];
    end else begin : g_mid_r
      assign right_val = cell_val[i+1];
    end

    pls_cell u_cell (
      .clk       (clk),
      .cell_idx  (pls_pkg::IDX_W'(i)),
      .bcast     (bcast),
      .left_val  (left_val),
      .right_val (right_val),
      .val       (cell_val[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      out_strobe_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

endmodule

// File: rtl/pls_cell.sv
// ----------------------------------------------------------------------------
// pls_cell: one storage cell of the positional list store
// Holds one item and, on each committed change, takes the new item, the
// item of its front neighbour, the item of its back neighbour, or holds.
// ----------------------------------------------------------------------------
module pls_cell (
  input  logic                          clk,
  input  logic [pls_pkg::IDX_W-1:0]     cell_idx,
  input  pls_pkg::pls_bcast_t           bcast,
  input  logic [pls_pkg::VAL_W-1:0]     left_val,
  input  logic [pls_pkg::VAL_W-1:0]     right_val,
  output logic [pls_pkg::VAL_W-1:0]     val
);

  logic [pls_pkg::VAL_W-1:0] val_r;
  logic [pls_pkg::VAL_W-1:0] val_nxt;
  logic [pls_pkg::CMP_W-1:0] idx_ext;

  assign idx_ext = pls_pkg::CMP_W'(cell_idx);

  always_comb begin
    val_nxt = val_r;
    if (bcast.ins) begin
      if (idx_ext == bcast.pos) begin
        val_nxt = bcast.value;
      end else if (idx_ext > bcast.pos) begin
        val_nxt = left_val;
      end
    end else if (bcast.rem) begin
      if (idx_ext >= bcast.pos) begin
        val_nxt = right_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

// File: sim/pls_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pls_checker: request/result checker for the positional list store
// Keeps its own copy of the list and the item count, works out the result of
// every request taken by the block and compares it with the result that
// appears later, oldest first.
// ----------------------------------------------------------------------------
module pls_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  pls_pkg::pls_in_t  in_data,
  input  logic              out_strobe,
  input  pls_pkg::pls_out_t out_data,
  output int                fail_count,
  output int                pending_results
);

  logic signed [pls_pkg::VAL_W-1:0] shadow_cells [pls_pkg::DEPTH];
  int                               shadow_count;
  pls_pkg::pls_out_t                awaited_results [$];
  int                               mismatches;

  assign fail_count = mismatches;

  function automatic pls_pkg::pls_out_t apply_request(pls_pkg::pls_in_t req);
    pls_pkg::pls_out_t res;
    int                pos;
    int                i;
    pos            = int'(req.position);
    res.success    = 1'b0;
    res.read_value = pls_pkg::NO_VALUE;
    case (req.action)
      pls_pkg::ACT_APPEND: begin
        if (shadow_count < pls_pkg::DEPTH) begin
          shadow_cells[shadow_count] = req.item_value;
          shadow_count++;
          res.success = 1'b1;
        end
      end
      pls_pkg::ACT_INSERT: begin
        if (pos <= shadow_count && shadow_count < pls_pkg::DEPTH) begin
          for (i = shadow_count; i > pos; i--) shadow_cells[i] = shadow_cells[i-1];
          shadow_cells[pos] = req.item_value;
          shadow_count++;
          res.success = 1'b1;
        end
      end
      pls_pkg::ACT_REMOVE: begin
        if (pos < shadow_count) begin
          for (i = pos; i + 1 < shadow_count; i++) shadow_cells[i] = shadow_cells[i+1];
          shadow_count--;
          res.success = 1'b1;
        end
      end
      default: begin
        if (pos < shadow_count) begin
          res.read_value = shadow_cells[pos];
          res.success    = 1'b1;
        end
      end
    endcase
    res.length = pls_pkg::POS_W'(shadow_count);
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] list store mismatch: %s", $time, what);
  endtask

  always @(posedge clk) begin
    pls_pkg::pls_out_t want;
    if (!rst_n) begin
      shadow_count = 0;
      awaited_results.delete();
    end else begin
      if (out_strobe) begin
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("result transfer with nothing outstanding: %p", out_data));
        end else begin
          want = awaited_results.pop_front();
          if (out_data.success !== want.success || out_data.read_value !== want.read_value ||
              out_data.length !== want.length)
            report_mismatch($sformatf("got success %b value %0d length %0d, expected %b %0d %0d",
                                      out_data.success, out_data.read_value, out_data.length,
                                      want.success, want.read_value, want.length));
        end
      end
      if (start && !busy) awaited_results.push_back(apply_request(in_data));
    end
    pending_results <= awaited_results.size();
  end

endmodule

// File: sim/tb_positional_list_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_positional_list_store: regression bench for the positional list store
// Drives directed corner requests and then random fill and drain bursts under
// varying sender gaps; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_positional_list_store;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  pls_pkg::pls_in_t  in_data;
  logic              out_strobe;
  pls_pkg::pls_out_t out_data;
  int                fail_count;
  int                pending_results;

  positional_list_store dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  pls_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_data         (in_data),
    .out_strobe      (out_strobe),
    .out_data        (out_data),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic pls_pkg::pls_in_t request(logic [1:0] act, int pos,
                                               logic signed [pls_pkg::VAL_W-1:0] val);
    pls_pkg::pls_in_t req;
    req.action     = act;
    req.position   = pls_pkg::POS_W'(pos);
    req.item_value = val;
    return req;
  endfunction

  function automatic pls_pkg::pls_in_t random_request(bit filling);
    int         r;
    int         p;
    int         pos;
    logic [1:0] act;
    logic signed [pls_pkg::VAL_W-1:0] val;
    r = $urandom_range(0, 99);
    if (filling) begin
      act = (r < 35) ? pls_pkg::ACT_APPEND : (r < 70) ? pls_pkg::ACT_INSERT :
            (r < 85) ? pls_pkg::ACT_REMOVE : pls_pkg::ACT_READ;
    end else begin
      act = (r < 10) ? pls_pkg::ACT_APPEND : (r < 25) ? pls_pkg::ACT_INSERT :
            (r < 70) ? pls_pkg::ACT_REMOVE : pls_pkg::ACT_READ;
    end
    p = $urandom_range(0, 99);
    if (p < 45) pos = $urandom_range(0, 8);
    else if (p < 88) pos = $urandom_range(0, 16);
    else pos = $urandom_range(0, 31);
    case ($urandom_range(0, 39))
      0:       val = 32'sh8000_0000;
      1:       val = 32'sh7fff_ffff;
      2:       val = 32'sd0;
      3:       val = -32'sd1;
      default: val = $urandom;
    endcase
    return request(act, pos, val);
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_request(input pls_pkg::pls_in_t req, input int idle_pct);
    while ($urandom_range(1, 100) <= idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start   <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    int idle_pcts [3];
    int k;
    int settle;
    bit filling;
    idle_pcts = '{21, 79, 0};
    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_request(request(pls_pkg::ACT_READ,   0, 32'sd0), 0);
    send_request(request(pls_pkg::ACT_REMOVE, 0, 32'sd0), 0);
    send_request(request(pls_pkg::ACT_INSERT, 1, 32'sd5), 0);
    send_request(request(pls_pkg::ACT_INSERT, 0, 32'sh8000_0000), 0);
    send_request(request(pls_pkg::ACT_APPEND, 9, 32'sh7fff_ffff), 0);
    send_request(request(pls_pkg::ACT_INSERT, 1, 32'sd0), 0);
    send_request(request(pls_pkg::ACT_READ,   2, 32'sd0), 0);
    send_request(request(pls_pkg::ACT_READ,   3, 32'sd0), 0);
    for (k = 3; k < pls_pkg::DEPTH; k++)
      send_request(request(pls_pkg::ACT_INSERT, $urandom_range(0, k), $urandom), 0);
    send_request(request(pls_pkg::ACT_APPEND, 0, -32'sd1), 0);
    send_request(request(pls_pkg::ACT_INSERT, 0, -32'sd1), 0);
    send_request(request(pls_pkg::ACT_READ,   16, 32'sd0), 0);
    send_request(request(pls_pkg::ACT_REMOVE, 15, 32'sd0), 0);
    send_request(request(pls_pkg::ACT_REMOVE, 0, 32'sd0), 0);
    send_request(request(pls_pkg::ACT_READ,   0, 32'sd0), 0);

    foreach (idle_pcts[ph]) begin
      filling = 1'b1;
      for (k = 0; k < 160; k++) begin
        if (k % 16 == 15) filling = $urandom_range(0, 1);
        send_request(random_request(filling), idle_pcts[ph]);
      end
    end

    start  <= 1'b0;
    settle = 0;
    while (pending_results != 0 && settle < 64) begin
      @(negedge clk);
      settle++;
    end
    repeat (4) @(negedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
